FILE: rtl/core/ate_pkg.sv
// shared types and constants of the affine transform engine
`timescale 1ns / 1ps
package ate_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_CNT      = 16;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int S_TDATA_W     = 136;
    localparam int M_TDATA_W     = 96;
    localparam int QUEUE_DEPTH   = 2;

    // last sequencer step of each long command
    localparam logic [5:0] CMP_LAST_STEP = 6'd63;
    localparam logic [3:0] XF_LAST_STEP  = 4'd11;

    // command codes as they arrive on the stream
    typedef enum logic [1:0] {
        OP_WR_CUR  = 2'd0,
        OP_WR_OPD  = 2'd1,
        OP_COMPOSE = 2'd2,
        OP_XFORM   = 2'd3
    } t_op;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    // one classified command in the queue
    typedef struct packed {
        t_op                op;
        logic [3:0]         idx;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  px;
        logic [DATA_W-1:0]  py;
        logic [DATA_W-1:0]  pz;
    } t_cmd;

    // bookkeeping that travels with each multiply-accumulate
    typedef struct packed {
        logic       first;
        logic       last;
        logic       xf;
        logic [1:0] row;
        logic [1:0] col;
    } t_mac_tag;

endpackage

FILE: rtl/core/ate_front.sv
// front end: takes command beats, classifies them and queues them
`timescale 1ns / 1ps
module ate_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0] row[3:2] col[5:4] value[37:6] point_x[69:38] point_y[101:70] point_z[133:102]
    input  logic [ate_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           o_q_valid,
    input  logic                           i_q_ready,
    output ate_pkg::t_cmd                  o_q_cmd
);
    import ate_pkg::*;

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       dec_cmd;
    logic       push, pop;

    // field split of the incoming beat
    always_comb begin
        dec_cmd.op    = t_op'(s_axis_tdata[1:0]);
        dec_cmd.idx   = {s_axis_tdata[3:2], s_axis_tdata[5:4]};
        dec_cmd.value = s_axis_tdata[37:6];
        dec_cmd.px    = s_axis_tdata[69:38];
        dec_cmd.py    = s_axis_tdata[101:70];
        dec_cmd.pz    = s_axis_tdata[133:102];
    end

    assign s_axis_tready = (r_count != 2'(QUEUE_DEPTH));
    assign o_q_valid     = (r_count != 2'd0);
    assign o_q_cmd       = r_q[r_rd_ptr];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = o_q_valid && i_q_ready;

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

endmodule

FILE: rtl/core/ate_mac.sv
// shared multiply-accumulate pipeline with rounding and saturation
`timescale 1ns / 1ps
module ate_mac #(
    parameter int FRAC_BITS = ate_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_issue,
    input  logic signed [ate_pkg::DATA_W-1:0]  i_a,
    input  logic signed [ate_pkg::DATA_W-1:0]  i_b,
    input  ate_pkg::t_mac_tag                  i_tag,
    output logic                               o_res_valid,
    output logic [ate_pkg::DATA_W-1:0]         o_res_value,
    output logic                               o_res_sat,
    output ate_pkg::t_mac_tag                  o_res_tag,
    output logic                               o_busy
);
    import ate_pkg::*;

    localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(2147483647)) - ACC_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p_vld;
    t_mac_tag                 r_p_tag;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     r_s_vld;
    t_mac_tag                 r_s_tag;
    logic signed [ACC_W-1:0]  rnd;
    logic [DATA_W-1:0]        sat_val;
    logic                     sat_hit;
    logic                     r_res_vld;
    logic [DATA_W-1:0]        r_res_val;
    logic                     r_res_sat;
    t_mac_tag                 r_res_tag;

    // accumulate, restarting on the first term of a sum
    always_comb begin
        if (r_p_tag.first) begin
            n_acc = ACC_W'(r_prod);
        end else begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    // round to nearest, ties upward, then clamp to 32 bits
    always_comb begin
        rnd     = (r_acc + HALF) >>> FRAC_BITS;
        sat_hit = 1'b0;
        sat_val = rnd[DATA_W-1:0];
        if (rnd > SAT_MAX) begin
            sat_hit = 1'b1;
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (rnd < SAT_MIN) begin
            sat_hit = 1'b1;
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_s_vld   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_p_vld   <= i_issue;
            r_s_vld   <= r_p_vld && r_p_tag.last;
            r_res_vld <= r_s_vld;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_prod  <= i_a * i_b;
            r_p_tag <= i_tag;
        end
        if (r_p_vld) begin
            r_acc   <= n_acc;
            r_s_tag <= r_p_tag;
        end
        if (r_s_vld) begin
            r_res_val <= sat_val;
            r_res_sat <= sat_hit;
            r_res_tag <= r_s_tag;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res_value = r_res_val;
    assign o_res_sat   = r_res_sat;
    assign o_res_tag   = r_res_tag;
    assign o_busy      = r_p_vld || r_s_vld || r_res_vld;

endmodule

FILE: rtl/core/ate_back.sv
// back end: matrix storage, command sequencer and result register
`timescale 1ns / 1ps
module ate_back #(
    parameter int FRAC_BITS = ate_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    output logic                           o_q_ready,
    input  ate_pkg::t_cmd                  i_q_cmd,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x[31:0] out_y[63:32] out_z[95:64]
    output logic [ate_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // overflow[0]
    output logic [0:0]                     m_axis_tuser
);
    import ate_pkg::*;

    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) <<< FRAC_BITS;

    logic [DATA_W-1:0]        r_cur [ELEM_CNT];
    logic [DATA_W-1:0]        r_opd [ELEM_CNT];
    t_state                   r_state, n_state;
    logic [5:0]               r_cnt, n_cnt;
    logic                     r_xf, n_xf;
    logic [DATA_W-1:0]        r_px, r_py, r_pz;
    logic [DATA_W-1:0]        r_res_x, r_res_y;
    logic                     r_ovf;
    logic [DATA_W-1:0]        r_rowbuf [3];
    logic                     r_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic                     r_out_ovf;
    logic                     pop, issue, last_step;
    logic [1:0]               k;
    logic [3:0]               cur_addr;
    logic [DATA_W-1:0]        cur_rd, opd_rd, pt_sel;
    logic signed [DATA_W-1:0] mac_a, mac_b;
    t_mac_tag                 mac_tag;
    logic                     res_valid, res_sat, mac_busy;
    logic [DATA_W-1:0]        res_value;
    t_mac_tag                 res_tag;

    assign last_step = r_xf ? (r_cnt[3:0] == XF_LAST_STEP) : (r_cnt == CMP_LAST_STEP);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_xf    = r_xf;
        pop     = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op) inside
                        OP_WR_CUR, OP_WR_OPD: begin
                            pop = 1'b1;
                        end
                        OP_COMPOSE: begin
                            pop     = 1'b1;
                            n_state = ST_ISSUE;
                            n_cnt   = 6'd0;
                            n_xf    = 1'b0;
                        end
                        OP_XFORM: begin
                            if (!r_out_valid) begin
                                pop     = 1'b1;
                                n_state = ST_ISSUE;
                                n_cnt   = 6'd0;
                                n_xf    = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                issue = 1'b1;
                if (last_step) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_q_ready = pop;

    // operand selection: compose walks i,j,k; transform walks column c and term k
    assign k        = r_cnt[1:0];
    assign cur_addr = r_xf ? {k, r_cnt[3:2]} : {r_cnt[5:4], k};
    assign cur_rd   = r_cur[cur_addr];
    assign opd_rd   = r_opd[{k, r_cnt[3:2]}];

    always_comb begin
        case (k)
            2'd0:    pt_sel = r_px;
            2'd1:    pt_sel = r_py;
            default: pt_sel = r_pz;
        endcase
        if (!r_xf) begin
            mac_a = cur_rd;
            mac_b = opd_rd;
        end else if (k == 2'd3) begin
            mac_a = cur_rd;
            mac_b = ONE;
        end else begin
            mac_a = pt_sel;
            mac_b = cur_rd;
        end
        mac_tag.first = (k == 2'd0);
        mac_tag.last  = (k == 2'd3);
        mac_tag.xf    = r_xf;
        mac_tag.row   = r_cnt[5:4];
        mac_tag.col   = r_cnt[3:2];
    end

    ate_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_a         (mac_a),
        .i_b         (mac_b),
        .i_tag       (mac_tag),
        .o_res_valid (res_valid),
        .o_res_value (res_value),
        .o_res_sat   (res_sat),
        .o_res_tag   (res_tag),
        .o_busy      (mac_busy)
    );

    // control state, matrices and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= 6'd0;
            r_xf        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ELEM_CNT; i++) begin
                r_cur[i] <= ((i / 4) == (i % 4)) ? ONE : '0;
                r_opd[i] <= ((i / 4) == (i % 4)) ? ONE : '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_xf    <= n_xf;
            if (pop && i_q_cmd.op == OP_WR_CUR) begin
                r_cur[i_q_cmd.idx] <= i_q_cmd.value;
            end
            if (pop && i_q_cmd.op == OP_WR_OPD) begin
                r_opd[i_q_cmd.idx] <= i_q_cmd.value;
            end
            // the four elements of a finished product row are written back together
            if (res_valid && !res_tag.xf && res_tag.col == 2'd3) begin
                r_cur[{res_tag.row, 2'd0}] <= r_rowbuf[0];
                r_cur[{res_tag.row, 2'd1}] <= r_rowbuf[1];
                r_cur[{res_tag.row, 2'd2}] <= r_rowbuf[2];
                r_cur[{res_tag.row, 2'd3}] <= res_value;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (res_valid && res_tag.xf && res_tag.col == 2'd2) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // point latch, partial results and result payload
    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.op == OP_XFORM) begin
            r_px <= i_q_cmd.px;
            r_py <= i_q_cmd.py;
            r_pz <= i_q_cmd.pz;
        end
        if (res_valid && !res_tag.xf && res_tag.col != 2'd3) begin
            r_rowbuf[res_tag.col] <= res_value;
        end
        if (res_valid && res_tag.xf) begin
            case (res_tag.col)
                2'd0: begin
                    r_res_x <= res_value;
                    r_ovf   <= res_sat;
                end
                2'd1: begin
                    r_res_y <= res_value;
                    r_ovf   <= r_ovf | res_sat;
                end
                default: begin
                    r_out_data <= {res_value, r_res_y, r_res_x};
                    r_out_ovf  <= r_ovf | res_sat;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_ovf;

`ifndef NO_ASSERTIONS
    // a transform only runs while the result register is free
    a_xf_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE && r_xf) |-> !r_out_valid)
        else $error("transform running over a pending result");

    // the last coordinate never lands on an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_tag.xf && res_tag.col == 2'd2) |-> !r_out_valid)
        else $error("result register overwritten");

    // idle means the pipeline has drained
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mac_busy)
        else $error("idle with work in the pipeline");

    // commands leave the queue only in idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_ready |-> (r_state == ST_IDLE && i_q_valid))
        else $error("queue read outside idle");
`endif

endmodule

FILE: rtl/core/affine_transform_engine.sv
// A beat is stored in the command queue before the back end sees it; a transform result passes
// its 12 multiplies through the product, sum and result stages into the result register.
// One multiplier issues a term a cycle while a command runs; the back end takes the next
// command only once the pipeline has drained, and a transform waits until the previous result is taken.
// A two-entry command queue lets beats arrive while the back end works.
// Reset (synchronous, active low): both matrices return to identity, queue and result empty.
`timescale 1ns / 1ps
module affine_transform_engine #(
    parameter int FRAC_BITS = ate_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // cmd[1:0] row[3:2] col[5:4] value[37:6] point_x[69:38] point_y[101:70] point_z[133:102]
    input  logic [ate_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_x[31:0] out_y[63:32] out_z[95:64]
    output logic [ate_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // overflow[0]
    output logic [0:0]                     m_axis_tuser
);
    import ate_pkg::*;

    logic q_valid, q_ready;
    t_cmd q_cmd;

    // command intake
    ate_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_cmd       (q_cmd)
    );

    // command execution
    ate_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_cmd       (q_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the affine transform engine
`timescale 1ns / 1ps
module tb_top;
    import ate_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int ONE = 1 << FB;
    localparam longint CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        ovf;
    } t_point_res;

    typedef struct {
        t_op         op;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        bit          has_res;
        t_point_res  res;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // predictor state
    logic signed [31:0] cur_m [16];
    logic signed [31:0] opd_m [16];
    t_point_res         pending_pts [$];
    int                 n_err = 0;
    longint             cyc = 0;
    bit                 long_hold = 1'b0;

    affine_transform_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cyc);
        n_err++;
    endtask

    // round to nearest (ties up) and saturate a full-width sum; translation at full weight
    function automatic logic [31:0] round_sat(input logic signed [71:0] acc, ref bit sat);
        logic signed [71:0] t;
        t = (acc + (72'sd1 <<< (FB - 1))) >>> FB;
        if (t > 72'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (t < -72'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return t[31:0];
    endfunction

    function automatic void matrix_identity();
        for (int i = 0; i < 16; i++) begin
            cur_m[i] = ((i >> 2) == (i & 3)) ? ONE : 0;
            opd_m[i] = ((i >> 2) == (i & 3)) ? ONE : 0;
        end
    endfunction

    // apply one command to the matrix state, returning the point result for transforms
    function automatic bit apply_cmd(input t_row c, output t_point_res r);
        logic signed [31:0] prod [16];
        logic signed [71:0] acc;
        logic [31:0]        o [3];
        bit                 sat;
        sat = 1'b0;
        r = '{default: '0};
        case (c.op)
            OP_WR_CUR: cur_m[{c.row, c.col}] = c.value;
            OP_WR_OPD: opd_m[{c.row, c.col}] = c.value;
            OP_COMPOSE: begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += 72'(cur_m[i*4+k]) * 72'(opd_m[k*4+j]);
                        prod[i*4+j] = round_sat(acc, sat);
                    end
                cur_m = prod;
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    acc = 72'($signed(c.px)) * 72'(cur_m[k])
                        + 72'($signed(c.py)) * 72'(cur_m[4+k])
                        + 72'($signed(c.pz)) * 72'(cur_m[8+k])
                        + (72'(cur_m[12+k]) <<< FB);
                    o[k] = round_sat(acc, sat);
                end
                r = '{x: o[0], y: o[1], z: o[2], ovf: sat};
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 4 * ONE)) - 2 * ONE);
            2: return 32'($signed($urandom_range(0, 512)) - 256) <<< FB;
            3: return {32{1'b0}} | $urandom_range(0, 3) << 30;
            default: return 32'($signed($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // send one beat: random gap first, then hold valid until accepted
    task automatic send_beat(input t_row c);
        t_point_res r;
        int         gap;
        gap = $urandom_range(0, 6);
        if (($urandom & 7) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b0, c.pz, c.py, c.px, c.value, c.col, c.row, c.op};
        do @(posedge i_clk); while (!s_axis_tready);
        if (apply_cmd(c, r)) begin
            if (c.has_res && r != c.res) begin
                $display("typed expectation disagrees with predictor at cycle %0d", cyc);
                n_err++;
            end
            pending_pts.push_back(r);
        end
    endtask

    // result side: random stall per beat, plus one long hold so the queue backs up
    initial begin
        int stall;
        @(posedge i_rst_n);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                stall = 400;
                long_hold = 1'b0;
            end else begin
                stall = ($urandom & 3) == 0 ? 0 : $urandom_range(0, 6);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // compare each accepted point against the oldest expectation
    always @(posedge i_clk) begin
        t_point_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pts.size() == 0) begin
                report("unexpected beat", m_axis_tdata[31:0], 32'hx);
            end else begin
                e = pending_pts.pop_front();
                if (m_axis_tdata[31:0] !== e.x) report("out_x", m_axis_tdata[31:0], e.x);
                if (m_axis_tdata[63:32] !== e.y) report("out_y", m_axis_tdata[63:32], e.y);
                if (m_axis_tdata[95:64] !== e.z) report("out_z", m_axis_tdata[95:64], e.z);
                if (m_axis_tuser[0] !== e.ovf)
                    report("overflow", 32'(m_axis_tuser[0]), 32'(e.ovf));
            end
        end
    end

    initial begin
        t_row tbl [$];
        t_row c;
        matrix_identity();
        // directed rows: identity transforms, extremes, saturation, writes and compose
        tbl = '{
            '{OP_XFORM, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1,
              '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0}},
            '{OP_XFORM, 3, 3, 32'hffffffff, 32'h7fffffff, 32'h80000000, 0, 1,
              '{32'h7fffffff, 32'h80000000, 0, 0}},
            '{OP_WR_CUR, 3, 0, 32'h7fffffff, 0, 0, 0, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'h7fffffff, 0, 0, 1,
              '{32'h7fffffff, 0, 0, 1}},
            '{OP_WR_CUR, 3, 0, 32'h80000000, 0, 0, 0, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'h80000000, 0, 0, 1,
              '{32'h80000000, 0, 0, 1}},
            '{OP_WR_CUR, 3, 0, 0, 0, 0, 0, 0, '{default: 0}},
            '{OP_WR_CUR, 0, 1, 32'h0000_8000, 0, 0, 0, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'h0000_0001, 0, 0, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'hffff_ffff, 0, 0, 0, '{default: 0}},
            '{OP_WR_OPD, 0, 0, 32'h0002_0000, 0, 0, 0, 0, '{default: 0}},
            '{OP_WR_OPD, 3, 2, 32'h0005_0000, 0, 0, 0, 0, '{default: 0}},
            '{OP_WR_OPD, 1, 3, 32'h80000000, 0, 0, 0, 0, '{default: 0}},
            '{OP_COMPOSE, 3, 3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0,
              '{default: 0}},
            '{OP_XFORM, 2, 1, 32'h12345678, 32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, 0,
              '{default: 0}},
            '{OP_WR_OPD, 2, 2, 32'h7fffffff, 0, 0, 0, 0, '{default: 0}},
            '{OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, '{default: 0}},
            '{OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '{default: 0}},
            '{OP_XFORM, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, '{default: 0}}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (tbl[i]) send_beat(tbl[i]);
        // random part: mostly moderate matrices, occasional reload to identity
        for (int n = 0; n < 1700; n++) begin
            if (n == 300) long_hold = 1'b1;
            c.op    = t_op'($urandom_range(0, 3));
            if (($urandom & 3) == 0) c.op = OP_XFORM;
            if (c.op == OP_COMPOSE && ($urandom & 1)) c.op = OP_WR_OPD;
            c.row   = 2'($urandom); c.col = 2'($urandom);
            c.value = rnd_val();
            if ((c.op == OP_WR_CUR || c.op == OP_WR_OPD) && ($urandom & 3) == 0)
                c.value = (c.row == c.col) ? ONE : 0;
            c.px = rnd_val(); c.py = rnd_val(); c.pz = rnd_val();
            c.has_res = 1'b0;
            c.res = '{default: 0};
            send_beat(c);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_pts.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
